// File: rtl/core/chfxy_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
`timescale 1ns / 1ps

package chfxy_pkg;

   // Field widths fixed by the sample and result formats
   localparam int READING_W = 16;
   localparam int HEADING_W = 9;

   // Internal fixed point: 8 guard bits on the vector, angle in 1/128 degree
   localparam int GUARD_BITS = 8;
   localparam int DEG_SHIFT  = 7;
   localparam int DEG_UNITS  = 1 << DEG_SHIFT;
   localparam int VEC_W      = READING_W + 1;            // holds the negated minimum
   localparam int CORE_W     = VEC_W + GUARD_BITS + 2;   // CORDIC gain headroom
   localparam int ANG_W      = 17;                       // about +/-360 degrees plus the sum
   localparam int ANG_TABLE_LEN = 24;

   localparam int HALF_TURN    = 180 * DEG_UNITS;
   localparam int QUARTER_TURN = 90 * DEG_UNITS;
   localparam int FULL_TURN    = 360 * DEG_UNITS;

   localparam int CORDIC_STAGES_DEFAULT = 16;

   // Queue between classifier and CORDIC pipeline
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [READING_W-1:0] x_reading;
      logic signed [READING_W-1:0] y_reading;
   } chfxy_req_type;

   typedef struct packed {
      logic [HEADING_W-1:0] heading_degrees;
      logic                 zero_vector;
   } chfxy_rsp_type;

   // Classified sample: vector folded into the right half-plane plus start angle
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } chfxy_item_type;

   // atan(2^-i) in 1/128 degree, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         0:       val = ANG_W'(5760);
         1:       val = ANG_W'(3400);
         2:       val = ANG_W'(1797);
         3:       val = ANG_W'(912);
         4:       val = ANG_W'(458);
         5:       val = ANG_W'(229);
         6:       val = ANG_W'(115);
         7:       val = ANG_W'(57);
         8:       val = ANG_W'(29);
         9:       val = ANG_W'(14);
         10:      val = ANG_W'(7);
         11:      val = ANG_W'(4);
         12:      val = ANG_W'(2);
         13:      val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/chfxy_front.sv
// Front end: accept a sample, fold it into the right half-plane, pick the start angle.
`timescale 1ns / 1ps

module chfxy_front
   import chfxy_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  chfxy_req_type  req_data,
   output logic           item_valid,
   input  logic           item_ready,
   output chfxy_item_type item_data
);

   logic           valid_ff, valid_in;
   chfxy_item_type item_ff, item_in;
   logic           take;
   logic signed [VEC_W-1:0] x_ext, y_ext;

   assign req_ready = !valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      x_ext        = VEC_W'(req_data.x_reading);
      y_ext        = VEC_W'(req_data.y_reading);
      item_in.zero = (req_data.x_reading == '0) && (req_data.y_reading == '0);
      // Left half-plane: negate the vector, start at +/-180 by the sign of y
      if (req_data.x_reading[READING_W-1]) begin
         item_in.x = -x_ext;
         item_in.y = -y_ext;
         item_in.z = req_data.y_reading[READING_W-1] ? -ANG_W'(HALF_TURN) : ANG_W'(HALF_TURN);
      end else begin
         item_in.x = x_ext;
         item_in.y = y_ext;
         item_in.z = '0;
      end
      valid_in = take ? 1'b1 : (item_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = item_ff;

endmodule

// File: rtl/core/chfxy_queue.sv
// Short FIFO that decouples the classifier from the CORDIC pipeline.
`timescale 1ns / 1ps

module chfxy_queue
   import chfxy_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  chfxy_item_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output chfxy_item_type pop_data
);

   chfxy_item_type    mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/chfxy_back.sv
// Back end: pipelined CORDIC vectoring, angle wrap and the output register.
`timescale 1ns / 1ps

module chfxy_back
   import chfxy_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_ready,
   input  chfxy_item_type item_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output chfxy_rsp_type  rsp_data
);

   localparam int EXT_W = CORE_W - VEC_W - GUARD_BITS;

   logic signed [CORE_W-1:0] x_ff [0:CORDIC_STAGES];
   logic signed [CORE_W-1:0] y_ff [0:CORDIC_STAGES];
   logic signed [ANG_W-1:0]  z_ff [0:CORDIC_STAGES];
   logic                     zero_ff [0:CORDIC_STAGES];
   logic signed [CORE_W-1:0] x_in [1:CORDIC_STAGES];
   logic signed [CORE_W-1:0] y_in [1:CORDIC_STAGES];
   logic signed [ANG_W-1:0]  z_in [1:CORDIC_STAGES];
   logic [CORDIC_STAGES:0]   valid_ff, valid_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   chfxy_rsp_type            rsp_data_ff, rsp_data_in;
   logic                     advance;
   logic signed [ANG_W-1:0]  z_off, z_wrap;

   // The whole pipe moves together; it halts only while the output beat waits
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign item_ready = advance;

   always_comb begin
      valid_in     = {valid_ff[CORDIC_STAGES-1:0], item_valid};
      rsp_valid_in = advance ? valid_ff[CORDIC_STAGES] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load stage: scale by the guard bits
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= {{EXT_W{item_data.x[VEC_W-1]}}, item_data.x, {GUARD_BITS{1'b0}}};
         y_ff[0]    <= {{EXT_W{item_data.y[VEC_W-1]}}, item_data.y, {GUARD_BITS{1'b0}}};
         z_ff[0]    <= item_data.z;
         zero_ff[0] <= item_data.zero;
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      logic signed [CORE_W-1:0] xs, ys;
      logic signed [ANG_W-1:0]  ang;

      always_comb begin
         xs  = x_ff[k] >>> k;
         ys  = y_ff[k] >>> k;
         ang = atan_entry(k);
         // y >= 0: rotate clockwise and grow the angle
         if (!y_ff[k][CORE_W-1]) begin
            x_in[k+1] = x_ff[k] + ys;
            y_in[k+1] = y_ff[k] - xs;
            z_in[k+1] = z_ff[k] + ang;
         end else begin
            x_in[k+1] = x_ff[k] - ys;
            y_in[k+1] = y_ff[k] + xs;
            z_in[k+1] = z_ff[k] - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]    <= x_in[k+1];
            y_ff[k+1]    <= y_in[k+1];
            z_ff[k+1]    <= z_in[k+1];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   // Shift by a quarter turn, wrap into one turn, drop the fraction of a degree
   always_comb begin
      z_off = z_ff[CORDIC_STAGES] + ANG_W'(QUARTER_TURN);
      if (z_off[ANG_W-1]) begin
         z_wrap = z_off + ANG_W'(FULL_TURN);
      end else if (z_off >= ANG_W'(FULL_TURN)) begin
         z_wrap = z_off - ANG_W'(FULL_TURN);
      end else begin
         z_wrap = z_off;
      end
      rsp_data_in.zero_vector = zero_ff[CORDIC_STAGES];
      if (zero_ff[CORDIC_STAGES]) begin
         rsp_data_in.heading_degrees = '0;
      end else begin
         rsp_data_in.heading_degrees = z_wrap[DEG_SHIFT +: HEADING_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/compass_heading_from_xy.sv
// Top level of the compass heading block: classifier, queue and CORDIC pipeline.
`timescale 1ns / 1ps

// Channel   Ports                             Beat
// --------  --------------------------------  -----------------------------------
// request   req_valid  req_ready  req_data    x_reading, y_reading (signed 16 bit)
// response  rsp_valid  rsp_ready  rsp_data    heading_degrees (0..359), zero_vector
//
// One beat in and one beat out per cycle when rsp_ready stays high.
// Samples pass the front register, the queue, the load stage, one register per
// CORDIC rotation, and the wrap/output register.
// Reset clears the valid flags and the queue pointers; nothing has to be swept.
// A stall on rsp_ready freezes the CORDIC pipe; the two-entry queue and the
// front register keep taking samples until they fill.

module compass_heading_from_xy
   import chfxy_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  chfxy_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output chfxy_rsp_type rsp_data
);

   // Classified samples travel front -> queue -> back
   logic           front_valid, front_ready;
   chfxy_item_type front_data;
   logic           back_valid, back_ready;
   chfxy_item_type back_data;

   // Fold the vector and pick the start angle
   chfxy_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_data)
   );

   // Absorb short stalls so the front can keep accepting
   chfxy_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   // Rotate, accumulate the angle, wrap and hold the result beat
   chfxy_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item_data  (back_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // A zero vector always reports heading zero
   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |-> rsp_data.heading_degrees == '0)
      else $error("zero vector with nonzero heading");

   // The wrap keeps every heading below a full turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading_degrees < HEADING_W'(360))
      else $error("heading out of range");

   // Nothing is offered in the first cycle out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
